### hw/rtl/markup_script_content_detector_top_macros.svh
// assertion macros for the markup and script content detector
// used by markup_script_content_detector_top; expects clk and rst_n in scope
`ifndef MARKUP_SCRIPT_CONTENT_DETECTOR_TOP_MACROS_SVH
`define MARKUP_SCRIPT_CONTENT_DETECTOR_TOP_MACROS_SVH

// check that is off while reset is asserted
`define MCSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also covers the reset cycles
`define MCSD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/mcsd_pkg.sv
// shared types, keyword table and match function for the content detector
// no dependencies
package mcsd_pkg;

  localparam int HIST_DEPTH = 8;
  localparam int KW_COUNT   = 10;
  localparam int KW_MAXLEN  = 9;

  // keyword groups: first group needs one of second group too
  localparam logic [KW_COUNT-1:0] GROUP_A_MASK = 10'h14F;
  localparam logic [KW_COUNT-1:0] GROUP_B_MASK = 10'h2B0;

  // tag matcher codes
  localparam logic [1:0] TAG_IDLE  = 2'd0;
  localparam logic [1:0] TAG_OPEN  = 2'd1;
  localparam logic [1:0] TAG_INNER = 2'd2;

  localparam logic [7:0] CH_LT = "<";
  localparam logic [7:0] CH_GT = ">";

  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  // per-beat control for the history chain and the matcher
  typedef struct packed {
    logic shift;
    logic flush;
  } ctrl_t;

  // verdict of a field as it stands after the current beat
  typedef struct packed {
    logic tag;
    logic script;
  } verdict_t;

  // keyword lengths
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd6, 4'd4, 4'd1, 4'd9, 4'd6, 4'd5, 4'd6, 4'd8
  };

  // keywords stored last character first, so entry 0 meets the current byte
  localparam logic [7:0] KW_REV [KW_COUNT][KW_MAXLEN] = '{
    '{" ", "r", "a", "v", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{" ", "t", "e", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{" ", "t", "s", "n", "o", "c", 8'h00, 8'h00, 8'h00},
    '{"l", "a", "v", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{" ", "n", "o", "i", "t", "c", "n", "u", "f"},
    '{" ", "c", "n", "y", "s", "a", 8'h00, 8'h00, 8'h00},
    '{"t", "i", "a", "w", "a", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"(", "t", "r", "e", "l", "a", 8'h00, 8'h00, 8'h00},
    '{".", "e", "l", "o", "s", "n", "o", "c", 8'h00}
  };

  // keyword k ends on the current byte
  function automatic logic kw_hit(input logic [3:0] k, input logic [7:0] cur,
                                  input hist_t hist, input logic [HIST_DEPTH-1:0] hvld);
    logic hit;
    hit = (cur == KW_REV[k][0]);
    for (int j = 1; j < KW_MAXLEN; j++) begin
      if (4'(j) < KW_LEN[k]) begin
        hit = hit & hvld[j-1] & (hist[j-1] == KW_REV[k][j]);
      end
    end
    return hit;
  endfunction

endpackage

### hw/rtl/mcsd_hist_cell.sv
// one byte cell of the history shift chain
// depends on mcsd_pkg
module mcsd_hist_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mcsd_pkg::ctrl_t ctrl,
  input  logic [7:0]     d_byte,
  input  logic           d_vld,
  output logic [7:0]     q_byte,
  output logic           q_vld
);

  logic [7:0] byte_r;
  logic       vld_r;
  logic       vld_nxt;

  // valid follows the neighbor, flushed at the end of a field
  always_comb begin
    vld_nxt = vld_r;
    if (ctrl.flush) begin
      vld_nxt = 1'b0;
    end else if (ctrl.shift) begin
      vld_nxt = d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // byte payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_r <= d_byte;
    end
  end

  assign q_byte = byte_r;
  assign q_vld  = vld_r;

endmodule

### hw/rtl/mcsd_detect.sv
// tag matcher, sticky keyword flags and field verdict
// depends on mcsd_pkg
module mcsd_detect (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mcsd_pkg::ctrl_t                ctrl,
  input  logic [7:0]                     cur,
  input  mcsd_pkg::hist_t                hist,
  input  logic [mcsd_pkg::HIST_DEPTH-1:0] hvld,
  output mcsd_pkg::verdict_t             verdict
);

  logic [1:0]                      tag_state_r, tag_state_nxt;
  logic                            tag_seen_r, tag_seen_nxt;
  logic [mcsd_pkg::KW_COUNT-1:0]   kw_seen_r, kw_seen_nxt;
  logic [mcsd_pkg::KW_COUNT-1:0]   kw_hit_now;

  // tag matcher step; state 3 never occurs and behaves like inner
  always_comb begin
    tag_state_nxt = tag_state_r;
    tag_seen_nxt  = tag_seen_r;
    if (cur == mcsd_pkg::CH_LT) begin
      tag_state_nxt = mcsd_pkg::TAG_OPEN;
    end else if (cur == mcsd_pkg::CH_GT) begin
      case (tag_state_r)
        mcsd_pkg::TAG_IDLE: tag_seen_nxt = tag_seen_r;
        mcsd_pkg::TAG_OPEN: tag_seen_nxt = tag_seen_r;
        default:            tag_seen_nxt = 1'b1;
      endcase
      tag_state_nxt = mcsd_pkg::TAG_IDLE;
    end else if (tag_state_r != mcsd_pkg::TAG_IDLE) begin
      tag_state_nxt = mcsd_pkg::TAG_INNER;
    end
  end

  // one comparator row per keyword
  for (genvar g = 0; g < mcsd_pkg::KW_COUNT; g++) begin : g_kw
    assign kw_hit_now[g] = mcsd_pkg::kw_hit(4'(g), cur, hist, hvld);
  end

  assign kw_seen_nxt = kw_seen_r | kw_hit_now;

  // verdict including the current beat
  assign verdict.tag    = tag_seen_nxt;
  assign verdict.script = (|(kw_seen_nxt & mcsd_pkg::GROUP_A_MASK)) &
                          (|(kw_seen_nxt & mcsd_pkg::GROUP_B_MASK));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_state_r <= mcsd_pkg::TAG_IDLE;
      tag_seen_r  <= 1'b0;
      kw_seen_r   <= '0;
    end else if (ctrl.flush) begin
      tag_state_r <= mcsd_pkg::TAG_IDLE;
      tag_seen_r  <= 1'b0;
      kw_seen_r   <= '0;
    end else if (ctrl.shift) begin
      tag_state_r <= tag_state_nxt;
      tag_seen_r  <= tag_seen_nxt;
      kw_seen_r   <= kw_seen_nxt;
    end
  end

endmodule

### hw/rtl/markup_script_content_detector_top.sv
// Markup and script content detector. Takes one byte of a text field per beat, with
// in_last on the final byte, and in the next cycle gives one result beat: tag_found,
// script_found and dangerous. A byte is taken every cycle unless stalled; the rate is
// set by the eight-cell history chain, which moves one byte per cycle and feeds the
// keyword comparators directly. The result sits in an output register; while it waits
// with out_ready low, in_ready is low and every input byte stalls, and a result taken
// in the same cycle as a new last byte makes room for the next one. All field state
// clears after the last byte. An empty field sends no beats and yields no result.
// depends on mcsd_pkg, mcsd_hist_cell, mcsd_detect and the macros header
`include "markup_script_content_detector_top_macros.svh"

module markup_script_content_detector_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_tag_found,
  output logic       out_script_found,
  output logic       out_dangerous
);

  mcsd_pkg::ctrl_t                  ctrl;
  mcsd_pkg::hist_t                  hist;
  logic [mcsd_pkg::HIST_DEPTH-1:0]  hvld;
  mcsd_pkg::verdict_t               verdict;
  logic                             take;
  logic                             out_valid_r, out_valid_nxt;
  logic                             tag_r, script_r;

  // input beat taken whenever the result slot is free or draining
  assign in_ready   = !out_valid_r || out_ready;
  assign take       = in_valid && in_ready;
  assign ctrl.shift = take;
  assign ctrl.flush = take && in_last;

  // history chain, newest byte in cell 0
  for (genvar i = 0; i < mcsd_pkg::HIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      mcsd_hist_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .d_byte (in_data_byte),
        .d_vld  (1'b1),
        .q_byte (hist[i]),
        .q_vld  (hvld[i])
      );
    end else begin : g_body
      mcsd_hist_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .d_byte (hist[i-1]),
        .d_vld  (hvld[i-1]),
        .q_byte (hist[i]),
        .q_vld  (hvld[i])
      );
    end
  end

  mcsd_detect u_detect (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .cur     (in_data_byte),
    .hist    (hist),
    .hvld    (hvld),
    .verdict (verdict)
  );

  // result slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.flush) begin
      tag_r    <= verdict.tag;
      script_r <= verdict.script;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_found    = tag_r;
  assign out_script_found = script_r;
  assign out_dangerous    = tag_r | script_r;

  // checks
  `MCSD_ASSERT_RST(a_rst_no_result, !rst_n |=> !out_valid_r, "result valid after reset")
  `MCSD_ASSERT(a_flush_clears_hist, ctrl.flush |=> (hvld == '0), "history not cleared after last beat")
  `MCSD_ASSERT(a_hist_contiguous, (hvld[7:1] & ~hvld[6:0]) == 7'd0, "history valid bits have a gap")
  `MCSD_ASSERT(a_result_on_last, (out_valid_r && !$past(out_valid_r)) |-> $past(ctrl.flush), "result without last beat")

endmodule
